### sv/fwsc_pkg.sv
// ----------------------------------------------------------------------------
// fwsc_pkg: shared types and constants for the wheel speed compensator
// Holds the channel payload structs, the controller command struct and the
// fixed-point constants of the incremental PI update.
// ----------------------------------------------------------------------------
`default_nettype none

package fwsc_pkg;

   // Number of wheel loops that carry state.
   localparam int CHANNELS = 4;
   localparam logic [2:0] CHAN_COUNT = 3'(CHANNELS);

   // Configuration register file: index bit 0 picks the gain, bits 2:1 the channel.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic GAIN_SEL_NOW  = 1'b0;
   localparam logic GAIN_SEL_PREV = 1'b1;

   // Gain reset values, unsigned Q1.15.
   localparam logic [15:0] GAIN_NOW_RESET  [4] = '{16'd15871, 16'd19598, 16'd14733, 16'd15307};
   localparam logic [15:0] GAIN_PREV_RESET [4] = '{16'd5201, 16'd6457, 16'd6362, 16'd6533};

   // Output scaling: drive = floor(|u| / 192), clamped to DRIVE_MAX.
   localparam logic [11:0] DRIVE_MAX      = 12'd4095;
   localparam logic [31:0] MAG_CLAMP      = 32'd786432;   // (DRIVE_MAX + 1) * 192
   localparam logic [14:0] RECIP_THIRD    = 15'd21846;    // ceil(2^16 / 3)
   localparam logic signed [35:0] ROUND_HALF = 36'sd64;   // half an LSB of Q16.16 in Q.23

   typedef struct packed {
      logic [1:0]         wheel_channel;
      logic signed [15:0] reference_speed;
      logic signed [15:0] measured_speed;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  result_channel;
      logic [11:0] drive_magnitude;
      logic        drive_saturated;
   } rsp_payload_type;

   // One strobe per datapath step, issued by the controller.
   typedef struct packed {
      logic load;     // capture the input item and form the error
      logic mult;     // form both gain products
      logic accum;    // round, accumulate, saturate, update channel state
      logic scale;    // take the magnitude and check the drive clamp
      logic emit;     // finish the divide by three and load the result register
   } dp_cmd_type;

endpackage

`default_nettype wire

### sv/four_wheel_speed_compensator.sv
// ----------------------------------------------------------------------------
// four_wheel_speed_compensator: four-channel incremental PI wheel speed loop
// Each input transfer names a wheel channel with its reference and measured
// speed (signed Q8.8). The block updates that channel's control value
// u = u_prev + a*e - b*e_prev in signed Q16.16, saturating at 32 bits, and
// returns one result transfer with |u| scaled to PWM counts (|u| / 192,
// clamped to 4095) and a flag set when either clamp engaged.
// Gains a and b are unsigned Q1.15, two per channel, written through the
// csr_ port: index 2*ch is the present-error gain, 2*ch+1 the previous-error
// gain. Write them only while no item is in flight.
// Error, products, control value and scaled magnitude are registered in turn
// before the result register. One item at a time; the controller steps each
// item through error and multiply, accumulate, magnitude, and scaling, and the
// next item is taken in the same cycle the previous result is loaded.
// A stalled result holds its register; the block then finishes the item in
// flight and waits in its last step, stalling further input transfers.
// Reset (synchronous) restores the gain reset values, clears every channel's
// previous error and control, and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module four_wheel_speed_compensator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire fwsc_pkg::req_payload_type            req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output fwsc_pkg::rsp_payload_type                 rsp_data,
   input  wire logic                                 csr_write_en,
   input  wire logic [fwsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fwsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Step strobes from the controller to the datapath.
   fwsc_pkg::dp_cmd_type cmd;

   fwsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath owns the gains, the channel state and the result register.
   fwsc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

### sv/fwsc_ctrl.sv
// ----------------------------------------------------------------------------
// fwsc_ctrl: sequencing controller for the wheel speed compensator
// Walks one item through the datapath steps and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fwsc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fwsc_pkg::dp_cmd_type   cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MULT  = 5'b00010,
      ST_ACCUM = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      emit_go;
   logic      accept_ok;
   logic      take;

   // The result register can be loaded when empty or when its transfer completes now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;
   assign accept_ok = (state_ff == ST_IDLE) || emit_go;
   assign take      = req_valid && accept_ok;

   assign req_stall = !accept_ok;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  state_in = take ? ST_MULT : ST_IDLE;
         ST_MULT:  state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = take ? ST_MULT : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      cmd.load  = take;
      cmd.mult  = (state_ff == ST_MULT);
      cmd.accum = (state_ff == ST_ACCUM);
      cmd.scale = (state_ff == ST_SCALE);
      cmd.emit  = emit_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/fwsc_dp.sv
// ----------------------------------------------------------------------------
// fwsc_dp: datapath of the wheel speed compensator
// Gain registers, per-channel loop state, the two gain multipliers, the
// rounding accumulator with saturation and the drive scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module fwsc_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fwsc_pkg::dp_cmd_type                 cmd,
   input  wire fwsc_pkg::req_payload_type            req_data,
   input  wire logic                                 csr_write_en,
   input  wire logic [fwsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fwsc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output fwsc_pkg::rsp_payload_type                 rsp_data
);

   // Configuration and loop state.
   logic [15:0]        gain_now_ff  [fwsc_pkg::CHANNELS];
   logic [15:0]        gain_prev_ff [fwsc_pkg::CHANNELS];
   logic signed [16:0] last_error_ff   [fwsc_pkg::CHANNELS];
   logic signed [31:0] last_control_ff [fwsc_pkg::CHANNELS];

   // Working registers of the item in flight.
   logic [1:0]         ch_ff;
   logic signed [16:0] err_ff, err_in;
   logic signed [33:0] prod_now_ff, prod_now_in;
   logic signed [33:0] prod_prev_ff, prod_prev_in;
   logic signed [31:0] ctl_ff, ctl_in;
   logic               acc_sat_ff, acc_sat_in;
   logic [13:0]        quot_ff, quot_in;
   logic               big_ff, big_in;
   fwsc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic               ch_ok;
   logic [1:0]         csr_ch;
   logic               csr_ok;
   logic signed [33:0] gain_now_ext, gain_prev_ext, err_ext, last_err_ext;
   logic signed [35:0] term;
   logic signed [28:0] rounded;
   logic signed [32:0] u_wide;
   logic [31:0]        mag;
   logic [28:0]        third;
   logic [11:0]        drive;

   assign ch_ok  = ({1'b0, ch_ff} < fwsc_pkg::CHAN_COUNT);
   assign csr_ch = csr_index[2:1];
   assign csr_ok = ({1'b0, csr_ch} < fwsc_pkg::CHAN_COUNT);

   // Error in Q9.8 cannot overflow at 17 bits.
   assign err_in = {req_data.reference_speed[15], req_data.reference_speed}
                 - {req_data.measured_speed[15], req_data.measured_speed};

   // Both products are exact at 34 bits.
   always_comb begin
      gain_now_ext  = {18'd0, gain_now_ff[ch_ff]};
      gain_prev_ext = {18'd0, gain_prev_ff[ch_ff]};
      err_ext       = {{17{err_ff[16]}}, err_ff};
      last_err_ext  = {{17{last_error_ff[ch_ff][16]}}, last_error_ff[ch_ff]};
      prod_now_in   = gain_now_ext * err_ext;
      prod_prev_in  = gain_prev_ext * last_err_ext;
   end

   // Round half up from Q.23 to Q16.16, accumulate and saturate to 32 bits.
   always_comb begin
      term    = {{2{prod_now_ff[33]}}, prod_now_ff} - {{2{prod_prev_ff[33]}}, prod_prev_ff}
              + fwsc_pkg::ROUND_HALF;
      rounded = term[35:7];
      u_wide  = {last_control_ff[ch_ff][31], last_control_ff[ch_ff]}
              + {{4{rounded[28]}}, rounded};
      if (u_wide[32] != u_wide[31]) begin
         ctl_in     = u_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         acc_sat_in = 1'b1;
      end else begin
         ctl_in     = u_wide[31:0];
         acc_sat_in = 1'b0;
      end
   end

   // Magnitude and clamp check; below the clamp the magnitude fits 20 bits.
   always_comb begin
      mag     = ctl_ff[31] ? (~ctl_ff + 32'd1) : ctl_ff;
      big_in  = (mag >= fwsc_pkg::MAG_CLAMP);
      quot_in = mag[19:6];
   end

   // floor(q / 3) by reciprocal; exact for q below 12288.
   always_comb begin
      third = {15'd0, quot_ff} * {14'd0, fwsc_pkg::RECIP_THIRD};
      drive = big_ff ? fwsc_pkg::DRIVE_MAX : third[27:16];
      rsp_data_in.result_channel = ch_ff;
      if (ch_ok) begin
         rsp_data_in.drive_magnitude = drive;
         rsp_data_in.drive_saturated = acc_sat_ff || big_ff;
      end else begin
         rsp_data_in.drive_magnitude = '0;
         rsp_data_in.drive_saturated = 1'b0;
      end
   end

   assign rsp_data = rsp_data_ff;

   // Gains and loop state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fwsc_pkg::CHANNELS; i++) begin
            gain_now_ff[i]     <= fwsc_pkg::GAIN_NOW_RESET[i];
            gain_prev_ff[i]    <= fwsc_pkg::GAIN_PREV_RESET[i];
            last_error_ff[i]   <= '0;
            last_control_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en && csr_ok) begin
            if (csr_index[0] == fwsc_pkg::GAIN_SEL_PREV) begin
               gain_prev_ff[csr_ch] <= csr_wdata;
            end else begin
               gain_now_ff[csr_ch] <= csr_wdata;
            end
         end
         if (cmd.accum && ch_ok) begin
            last_error_ff[ch_ff]   <= err_ff;
            last_control_ff[ch_ff] <= ctl_in;
         end
      end
   end

   // Working registers hold payload only.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff  <= req_data.wheel_channel;
         err_ff <= err_in;
      end
      if (cmd.mult) begin
         prod_now_ff  <= prod_now_in;
         prod_prev_ff <= prod_prev_in;
      end
      if (cmd.accum) begin
         ctl_ff     <= ctl_in;
         acc_sat_ff <= acc_sat_in;
      end
      if (cmd.scale) begin
         quot_ff <= quot_in;
         big_ff  <= big_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
